>>> rtl/md5bc_pkg.sv
package md5bc_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_PRIME,
    ST_ROUND,
    ST_FINAL
  } state_t;

  // Working words a, b, c, d of the compression.
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } work_t;

  localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
  localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV3 = 32'h10325476;

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7,  5'd12, 5'd17, 5'd22,
    5'd5,  5'd9,  5'd14, 5'd20,
    5'd4,  5'd11, 5'd16, 5'd23,
    5'd6,  5'd10, 5'd15, 5'd21
  };

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [7:0] lo;
    logic [7:0] t;
    lo = {4'b0000, rnd[3:0]};
    case (rnd[5:4])
      2'd0:    t = lo;
      2'd1:    t = lo * 8'd5 + 8'd1;
      2'd2:    t = lo * 8'd3 + 8'd5;
      2'd3:    t = lo * 8'd7;
      default: t = lo;
    endcase
    return t[3:0];
  endfunction

endpackage

>>> rtl/md5_block_compress_unit.sv
// MD5 block compression unit.
//
// Input channel (msg_valid / msg_ready): one 32-bit message word per request,
// with restart set on the first word of a new message to reload the standard
// initial chaining value. Sixteen words make one block; a restart on any word
// drops the partial block and makes that word word 0.
// Output channel (digest_valid / digest_ready): after every sixteenth word the
// block runs the 64 MD5 rounds on one shared round unit, one round per cycle,
// and offers the updated chaining value as digest_a..digest_d.
// After the sixteenth word the unit is busy while it primes the message
// fetch pipeline, runs the 64 rounds and does the chaining add, and the
// digest is valid on the cycle after that add.
// Stalls: the digest sits in an output register, so words of the next block
// are taken while it waits; only the sixteenth word of that block is held off
// until the pending digest has been taken.
// Reset (rst, synchronous) loads the initial chaining value, clears the word
// count and drops any pending digest. The message buffer is not cleared.
module md5_block_compress_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [31:0] msg_word,
  input  logic        restart,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d
);

  md5bc_pkg::state_t state;
  md5bc_pkg::state_t state_next;

  logic [3:0]  word_count;
  logic [3:0]  word_count_next;
  logic [3:0]  wr_addr;
  logic        msg_accept;
  logic        prime_cnt;
  logic [5:0]  rnd;
  logic [5:0]  fidx;
  logic [31:0] rd_data;
  logic [31:0] kq;
  logic [31:0] mk;
  logic [31:0] chain [4];
  md5bc_pkg::work_t work;
  md5bc_pkg::work_t work_next;

  // A sixteenth word may only be taken once the previous digest is gone.
  always_comb begin
    state_next      = state;
    msg_ready       = 1'b0;
    word_count_next = word_count;
    wr_addr         = restart ? 4'd0 : word_count;
    case (state)
      md5bc_pkg::ST_COLLECT: begin
        msg_ready = !((word_count == 4'd15) && digest_valid);
        if (msg_valid && msg_ready) begin
          word_count_next = wr_addr + 4'd1;
          if (wr_addr == 4'd15) begin
            state_next = md5bc_pkg::ST_PRIME;
          end
        end
      end
      md5bc_pkg::ST_PRIME: begin
        if (prime_cnt) begin
          state_next = md5bc_pkg::ST_ROUND;
        end
      end
      md5bc_pkg::ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = md5bc_pkg::ST_FINAL;
        end
      end
      md5bc_pkg::ST_FINAL: begin
        state_next = md5bc_pkg::ST_COLLECT;
      end
      default: begin
        state_next = md5bc_pkg::ST_COLLECT;
      end
    endcase
  end

  assign msg_accept = msg_valid && msg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= md5bc_pkg::ST_COLLECT;
      word_count <= 4'd0;
    end else begin
      state      <= state_next;
      word_count <= word_count_next;
    end
  end

  // Sequencer counters. fidx runs two rounds ahead of rnd so that the
  // registered buffer read and the constant add are ready in time.
  always_ff @(posedge clk) begin
    if (rst) begin
      prime_cnt <= 1'b0;
      rnd       <= 6'd0;
      fidx      <= 6'd0;
    end else begin
      prime_cnt <= (state == md5bc_pkg::ST_PRIME) ? !prime_cnt : 1'b0;
      rnd       <= (state == md5bc_pkg::ST_ROUND) ? rnd + 6'd1 : 6'd0;
      fidx      <= (state == md5bc_pkg::ST_COLLECT) ? 6'd0 : fidx + 6'd1;
    end
  end

  md5bc_msg_buf u_buf (
    .clk     (clk),
    .wr_en   (msg_accept),
    .wr_addr (wr_addr),
    .wr_data (msg_word),
    .rd_addr (md5bc_pkg::msg_index(fidx)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    kq <= md5bc_pkg::ROUND_K[fidx];
    mk <= rd_data + kq;
  end

  md5bc_round u_round (
    .cur   (work),
    .phase (rnd[5:4]),
    .shamt (md5bc_pkg::ROT_AMT[{rnd[5:4], rnd[1:0]}]),
    .mk    (mk),
    .nxt   (work_next)
  );

  always_ff @(posedge clk) begin
    if (state == md5bc_pkg::ST_PRIME) begin
      work.a <= chain[0];
      work.b <= chain[1];
      work.c <= chain[2];
      work.d <= chain[3];
    end else if (state == md5bc_pkg::ST_ROUND) begin
      work <= work_next;
    end
  end

  // Chaining value: reloaded on restart, accumulated at the end of a block.
  always_ff @(posedge clk) begin
    if (rst || (msg_accept && restart)) begin
      chain[0] <= md5bc_pkg::IV0;
      chain[1] <= md5bc_pkg::IV1;
      chain[2] <= md5bc_pkg::IV2;
      chain[3] <= md5bc_pkg::IV3;
    end else if (state == md5bc_pkg::ST_FINAL) begin
      chain[0] <= chain[0] + work.a;
      chain[1] <= chain[1] + work.b;
      chain[2] <= chain[2] + work.c;
      chain[3] <= chain[3] + work.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (state == md5bc_pkg::ST_FINAL) begin
      digest_valid <= 1'b1;
    end else if (digest_ready) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == md5bc_pkg::ST_FINAL) begin
      digest_a <= chain[0] + work.a;
      digest_b <= chain[1] + work.b;
      digest_c <= chain[2] + work.c;
      digest_d <= chain[3] + work.d;
    end
  end

endmodule

>>> rtl/md5bc_msg_buf.sv
module md5bc_msg_buf (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/md5bc_round.sv
module md5bc_round (
  input  md5bc_pkg::work_t cur,
  input  logic [1:0]       phase,
  input  logic [4:0]       shamt,
  input  logic [31:0]      mk,
  output md5bc_pkg::work_t nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot;

  always_comb begin
    case (phase)
      2'd0:    f = cur.d ^ (cur.b & (cur.c ^ cur.d));
      2'd1:    f = cur.c ^ (cur.d & (cur.b ^ cur.c));
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      2'd3:    f = cur.c ^ (cur.b | ~cur.d);
      default: f = cur.b ^ cur.c ^ cur.d;
    endcase
  end

  // The message word and round constant arrive already summed as mk.
  assign sum   = cur.a + f + mk;
  assign rot   = {sum, sum} << shamt;
  assign nxt.a = cur.d;
  assign nxt.d = cur.c;
  assign nxt.c = cur.b;
  assign nxt.b = cur.b + rot[63:32];

endmodule

>>> rtl/md5bc_checker.sv
module md5bc_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_ready,
  input logic        digest_valid,
  input logic        digest_ready,
  input logic [31:0] digest_a,
  input logic [31:0] digest_b,
  input logic [31:0] digest_c,
  input logic [31:0] digest_d
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid)
    else $error("digest dropped before it was taken");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> $stable(digest_a) && $stable(digest_b)
      && $stable(digest_c) && $stable(digest_d))
    else $error("digest changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !digest_valid)
    else $error("digest valid after reset");

  a_busy_before_digest: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> !$past(msg_ready))
    else $error("digest appeared while words were being taken");

  a_no_second_digest: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready && msg_ready |=> !$rose(msg_ready))
    else $error("unit busy state changed oddly while digest pending");

endmodule

bind md5_block_compress_unit md5bc_checker u_md5bc_checker (
  .clk          (clk),
  .rst          (rst),
  .msg_ready    (msg_ready),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest_a     (digest_a),
  .digest_b     (digest_b),
  .digest_c     (digest_c),
  .digest_d     (digest_d)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Checks md5_block_compress_unit against a cycle-free MD5 predictor.
//
// Every accepted word request is fed to the predictor, which keeps its own
// chaining value, block buffer and word position. When a request completes
// a block, the predictor runs the 64 rounds and queues the expected digest.
// Each accepted digest is compared, word by word, with the oldest entry of
// that queue.
//
// The run has two parts. A short directed table comes first. It holds two
// well-known single-block messages, the empty string and "abc", with their
// published digests typed in. The first block follows reset without a
// restart. The second is preceded by a dropped partial block of all-ones
// words, so it starts with a restart in mid-block. A random part follows.
// Most of it is complete 16-word blocks with random content. Some blocks
// restart the chain and others chain from the previous digest. The rest is
// noise: short blocks, alignment shifts and scattered restarts.
//
// Both channels idle in four phases: no idling, sender idle most of the
// time, receiver stalled most of the time, and both idling now and then.
// At the start of the first phase, the receiver holds off for a long
// stretch while the sender keeps offering words. The unit then fills with
// words of the next block and has to stall its input until the pending
// digest is taken.
module testbench;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  // One row of the directed table: a run of identical words. The restart
  // flag applies to the first word of the run only. A known digest applies
  // to the last word of the run, which must complete a block.
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] word;
    logic        restart_first;
    logic        known;
    digest_t     digest;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 7;
  localparam int RAND_ITEMS   = 1210;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 120;

  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // Empty message, straight after reset, with no restart.
    '{32'd1,  32'h00000080, 1'b0, 1'b0, '0},
    '{32'd15, 32'h00000000, 1'b0, 1'b1,
      '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec}},
    // Partial block of all-ones words, later dropped by a restart.
    '{32'd5,  32'hffffffff, 1'b1, 1'b0, '0},
    // "abc" padded, the first word restarting in mid-block.
    '{32'd1,  32'h80636261, 1'b1, 1'b0, '0},
    '{32'd13, 32'h00000000, 1'b0, 1'b0, '0},
    '{32'd1,  32'h00000018, 1'b0, 1'b0, '0},
    '{32'd1,  32'h00000000, 1'b0, 1'b1,
      '{32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128}}
  };

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, four per group of sixteen rounds.
  localparam int MD5_SHIFT [16] = '{
    7, 12, 17, 22,
    5, 9, 14, 20,
    4, 11, 16, 23,
    6, 10, 15, 21
  };

  localparam digest_t MD5_IV = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_ready;
  logic [31:0] msg_word = '0;
  logic        restart = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  md5_block_compress_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .msg_word     (msg_word),
    .restart      (restart),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_a     (digest_a),
    .digest_b     (digest_b),
    .digest_c     (digest_c),
    .digest_d     (digest_d)
  );

  // Predictor state: the chaining value, the words of the current block and
  // the position of the next word within that block.
  digest_t     md5_chain = MD5_IV;
  logic [31:0] msg_buf [16];
  logic [3:0]  word_pos = '0;

  // Digests the unit still owes, oldest first.
  digest_t     pending_digests [$];

  int unsigned err_count = 0;
  int unsigned issued = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_ask = 1'b0;
  int unsigned hold_count = 0;
  bit          realign = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog. It stops a run that hangs and reports it as failed.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Runs the 64 MD5 rounds over the buffered block and folds the result
  // into the chaining value.
  function automatic digest_t md5_compress(input digest_t cv);
    logic [31:0] a, b, c, d, f, t;
    int          g, sh, grp;
    a = cv.a;
    b = cv.b;
    c = cv.c;
    d = cv.d;
    for (int r = 0; r < 64; r++) begin
      grp = r / 16;
      case (grp)
        0: begin
          f = d ^ (b & (c ^ d));
          g = r;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t  = a + f + msg_buf[g] + MD5_K[r];
      sh = MD5_SHIFT[grp * 4 + r % 4];
      t  = b + ((t << sh) | (t >> (32 - sh)));
      a  = d;
      d  = c;
      c  = b;
      b  = t;
    end
    md5_compress = '{cv.a + a, cv.b + b, cv.c + c, cv.d + d};
  endfunction

  // Takes one accepted word into the predictor. Returns 1 and the new
  // chaining value when the word completes a block.
  function automatic bit absorb_word(input logic [31:0] w, input logic rs,
                                     output digest_t dg);
    if (rs) begin
      // A restart reloads the initial value and makes this word word 0,
      // dropping whatever part of a block was buffered.
      md5_chain = MD5_IV;
      word_pos  = '0;
    end
    msg_buf[word_pos] = w;
    word_pos = word_pos + 4'd1;
    dg = md5_chain;
    if (word_pos != 4'd0) return 1'b0;
    md5_chain = md5_compress(md5_chain);
    dg = md5_chain;
    return 1'b1;
  endfunction

  // Message words biased toward the extremes and single-bit patterns.
  function automatic logic [31:0] pick_word();
    logic [31:0] one_hot;
    one_hot = 32'd1 << $urandom_range(31);
    case ($urandom_range(7))
      0:       pick_word = '0;
      1:       pick_word = '1;
      2:       pick_word = one_hot;
      3:       pick_word = ~one_hot;
      default: pick_word = $urandom;
    endcase
  endfunction

  // Offers one word request and waits until it is accepted. The caller is
  // just past a rising edge, so each step begins at the next falling edge.
  // A known digest, if given, replaces the predicted one.
  task automatic offer_word(input logic [31:0] w, input logic rs,
                            input bit known, input digest_t typed);
    digest_t dg;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(negedge clk);
    end
    msg_valid <= 1'b1;
    msg_word  <= w;
    restart   <= rs;
    do @(posedge clk); while (!msg_ready);
    issued++;
    if (absorb_word(w, rs, dg)) pending_digests.push_back(known ? typed : dg);
  endtask

  // One random run. Most runs are complete blocks; a few are cut short,
  // and half of those mark the next run to start with a restart to realign.
  // Now and then, restarts are scattered through a run.
  task automatic send_run();
    int unsigned kind, len;
    logic        rs;
    kind = $urandom_range(15);
    len  = (kind < 2) ? $urandom_range(1, 15) : 16;
    for (int k = 0; k < len; k++) begin
      if (kind == 15) rs = ($urandom_range(7) == 0);
      else            rs = (k == 0) && (realign || $urandom_range(3) == 0);
      offer_word(pick_word(), rs, 1'b0, '0);
    end
    realign = (kind == 0);
  endtask

  // Result side. A long hold-off, once asked for, comes first. Otherwise
  // ready follows the stall rate of the current phase.
  always @(negedge clk) begin
    if (rst) begin
      digest_ready <= 1'b0;
    end else if (hold_ask && hold_count < HOLD_LEN) begin
      digest_ready <= 1'b0;
      hold_count++;
    end else begin
      digest_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic field_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
    err_count++;
    if (err_count <= 10)
      $display("%t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Compares every accepted digest with the oldest expected digest.
  always @(posedge clk) begin : check_digest
    digest_t want;
    if (!rst && digest_valid && digest_ready) begin
      if (pending_digests.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%t: digest with none expected: %h %h %h %h", $realtime,
                   digest_a, digest_b, digest_c, digest_d);
      end else begin
        want = pending_digests.pop_front();
        if (digest_a !== want.a) field_mismatch("digest_a", want.a, digest_a);
        if (digest_b !== want.b) field_mismatch("digest_b", want.b, digest_b);
        if (digest_c !== want.c) field_mismatch("digest_c", want.c, digest_c);
        if (digest_d !== want.d) field_mismatch("digest_d", want.d, digest_d);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_end;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, without idling.
    for (int row = 0; row < NUM_DIR_ROWS; row++) begin
      for (int k = 0; k < DIR_ROWS[row].count; k++) begin
        offer_word(DIR_ROWS[row].word, (k == 0) && DIR_ROWS[row].restart_first,
                   DIR_ROWS[row].known && (k == DIR_ROWS[row].count - 1),
                   DIR_ROWS[row].digest);
      end
    end

    // Random part in four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // The sender keeps offering words while the receiver holds off.
          // The unit therefore fills up and stalls its input.
          hold_ask = 1'b1;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 80;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      phase_end = issued + RAND_ITEMS / 4;
      while (issued < phase_end) send_run();
    end

    @(negedge clk);
    msg_valid <= 1'b0;

    // Wait for every owed digest, then give the unit time to show any
    // digest it should not produce.
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && pending_digests.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/md5bc_pkg.sv
rtl/md5bc_msg_buf.sv
rtl/md5bc_round.sv
rtl/md5_block_compress_unit.sv
rtl/md5bc_checker.sv
verif/testbench.sv
